// ===== rtl/diphoton_event_selection_cuts_core_assert.svh =====
// Assertion macros for the diphoton event selection pipeline.
`ifndef DIPHOTON_EVENT_SELECTION_CUTS_CORE_ASSERT_SVH
`define DIPHOTON_EVENT_SELECTION_CUTS_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPSC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Pipeline check failed.");

// The consequent must hold in the cycle after the antecedent.
`define DPSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Pipeline check failed.");

`endif

// ===== rtl/dpsc_pkg.sv =====
// Shared constants and tables for the diphoton event selection pipeline.
package dpsc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 23;

  localparam logic [CfgIdxW-1:0] REG_BEAM_ENERGY    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LEAD_PT_CUT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SUBLEAD_PT_CUT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ETA_LIMIT      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CRACK_LOW      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CRACK_HIGH     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_MIN_DELTA_R    = 3'd6;

  localparam int LN_W         = 21;
  localparam int ANG_W        = 20;
  localparam int LOG_STEPS    = 16;
  localparam int CORDIC_STEPS = 16;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam logic signed [ANG_W-1:0] PI_ANG     = 20'sd205887;
  localparam logic signed [ANG_W:0]   PI_DPHI    = 21'sd205887;
  localparam logic signed [ANG_W:0]   TWO_PI_DPHI = 21'sd411774;
  localparam logic signed [21:0]      ETA_SAT    = 22'sd1048576;

  localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
    16'd51472, 16'd30385, 16'd16054, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
    16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
  };

endpackage

// ===== rtl/dpsc_log.sv =====
// Pipelined natural logarithm in Q.16 by repeated squaring of a normalised mantissa.
module dpsc_log import dpsc_pkg::*; #(
  parameter int XW = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [XW-1:0]           x_i,
  output logic [$clog2(XW)+15:0]  ln_o
);

  localparam int NW = $clog2(XW);
  localparam int RW = NW + 16;
  localparam int MW = 31;

  logic [NW-1:0]    n_d;
  logic [XW+29:0]   sh;
  logic [MW-1:0]    m_q [LOG_STEPS];
  logic [RW-1:0]    r_q [LOG_STEPS+1];
  logic [RW+31:0]   prod;
  logic [RW-1:0]    ln_q;

  always_comb begin
    n_d = '0;
    for (int j = 0; j < XW; j++) begin
      if (x_i[j]) begin
        n_d = NW'(j);
      end
    end
    sh = {x_i, 30'b0} >> n_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0] <= sh[MW-1:0];
      r_q[0] <= {n_d, 16'b0};
    end
  end

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
    logic [2*MW-1:0] p;
    logic [MW:0]     t;
    logic [RW-1:0]   r_d;

    always_comb begin
      p   = m_q[j] * m_q[j];
      t   = p[2*MW-1:MW-1];
      r_d = r_q[j];
      if (t[MW]) begin
        r_d[LOG_STEPS-1-j] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j+1] <= r_d;
      end
    end

    if (j < LOG_STEPS-1) begin : g_m
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[j+1] <= t[MW] ? t[MW:1] : t[MW-1:0];
        end
      end
    end
  end

  assign prod = r_q[LOG_STEPS] * LN2_Q32;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ln_q <= prod[RW+31:32];
    end
  end

  assign ln_o = ln_q;

endmodule

// ===== rtl/dpsc_cordic.sv =====
// Pipelined CORDIC angle of a momentum vector in Q.16 radians.
module dpsc_cordic import dpsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [23:0]      y_i,
  input  logic signed [23:0]      x_i,
  output logic signed [ANG_W-1:0] ang_o
);

  localparam int CW = 35;

  logic signed [CW-1:0]    xs, ys;
  logic signed [CW-1:0]    x_q [CORDIC_STEPS];
  logic signed [CW-1:0]    y_q [CORDIC_STEPS];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS+1];
  logic                    zero_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] ang_q;

  assign xs = CW'(x_i) <<< 8;
  assign ys = CW'(y_i) <<< 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        z_q[0] <= (y_i >= 0) ? PI_ANG : -PI_ANG;
        x_q[0] <= -xs;
        y_q[0] <= -ys;
      end else begin
        z_q[0] <= '0;
        x_q[0] <= xs;
        y_q[0] <= ys;
      end
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_it
    logic signed [ANG_W-1:0] at;
    logic signed [CW-1:0]    xn, yn;
    logic signed [ANG_W-1:0] zn;

    assign at = signed'({{(ANG_W-16){1'b0}}, ATAN_TAB[j]});

    always_comb begin
      if (y_q[j] > 0) begin
        xn = x_q[j] + (y_q[j] >>> j);
        yn = y_q[j] - (x_q[j] >>> j);
        zn = z_q[j] + at;
      end else begin
        xn = x_q[j] - (y_q[j] >>> j);
        yn = y_q[j] + (x_q[j] >>> j);
        zn = z_q[j] - at;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[j+1]    <= zn;
        zero_q[j+1] <= zero_q[j];
      end
    end

    if (j < CORDIC_STEPS-1) begin : g_xy
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[j+1] <= xn;
          y_q[j+1] <= yn;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= zero_q[CORDIC_STEPS] ? '0 : z_q[CORDIC_STEPS];
    end
  end

  assign ang_o = ang_q;

endmodule

// ===== rtl/diphoton_event_selection_cuts_core.sv =====
// Top level of the diphoton event selection pipeline: one reject flag per event item.
//
// Input channel: in_valid_i with in_stall_o; an item is taken when valid is high and
// stall is low. Each item carries the pair kinematics and both photon four-momenta.
// Output channel: out_valid_o with out_stall_i, carrying rejected_o for each item.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high and unknown indexes are ignored. Write only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The depth is set by
// the 16 squaring steps of the logarithm units and the 16 CORDIC steps, which run side
// by side over 18 stages. A stalled output holds the whole pipeline, so in_stall_o
// rises with it and nothing is lost or repeated. Reset clears all valid bits and loads
// the register defaults.
`include "diphoton_event_selection_cuts_core_assert.svh"

module diphoton_event_selection_cuts_core import dpsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [27:0]         pair_mass_sq_i,
  input  logic [27:0]         pair_qt_sq_i,
  input  logic signed [15:0]  pair_rapidity_i,
  input  logic [27:0]         scale_sq_i,
  input  logic [22:0]         photon1_energy_i,
  input  logic signed [23:0]  photon1_px_i,
  input  logic signed [23:0]  photon1_py_i,
  input  logic signed [23:0]  photon1_pz_i,
  input  logic [22:0]         photon2_energy_i,
  input  logic signed [23:0]  photon2_px_i,
  input  logic signed [23:0]  photon2_py_i,
  input  logic signed [23:0]  photon2_pz_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                rejected_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int NSTG = 22;
  localparam int SBN  = 18;

  typedef enum logic [1:0] {ETA_CALC, ETA_ZERO, ETA_POS, ETA_NEG} eta_mode_e;

  typedef struct packed {
    logic [31:0]        s;
    logic [27:0]        q2;
    logic signed [24:0] a1;
    logic signed [24:0] b1;
    logic signed [24:0] a2;
    logic signed [24:0] b2;
    logic signed [23:0] px1;
    logic signed [23:0] py1;
    logic signed [23:0] px2;
    logic signed [23:0] py2;
    logic [15:0]        ay;
    logic               qt_cut;
    logic [46:0]        sqx1;
    logic [46:0]        sqy1;
    logic [46:0]        sqx2;
    logic [46:0]        sqy2;
    logic [45:0]        c1s;
    logic [45:0]        c2s;
  } s1_t;

  typedef struct packed {
    logic      q2_nz;
    logic      s_nz;
    logic [15:0] ay;
    logic      base_cut;
    eta_mode_e mode1;
    eta_mode_e mode2;
  } sb_t;

  function automatic logic signed [21:0] eta_sel(eta_mode_e mode, logic [LN_W-1:0] lna,
                                                 logic [LN_W-1:0] lnb);
    logic signed [21:0] diff;
    logic signed [21:0] half;
    logic signed [21:0] res;
    diff = $signed({1'b0, lna}) - $signed({1'b0, lnb});
    half = diff >>> 1;
    if (half > ETA_SAT) begin
      half = ETA_SAT;
    end else if (half < -ETA_SAT) begin
      half = -ETA_SAT;
    end
    case (mode)
      ETA_ZERO: res = '0;
      ETA_POS:  res = ETA_SAT;
      ETA_NEG:  res = -ETA_SAT;
      default:  res = half;
    endcase
    return res;
  endfunction

  function automatic eta_mode_e eta_mode(logic signed [24:0] a, logic signed [24:0] b);
    eta_mode_e m;
    if (a <= 0 && b <= 0) begin
      m = ETA_ZERO;
    end else if (b <= 0) begin
      m = ETA_POS;
    end else if (a <= 0) begin
      m = ETA_NEG;
    end else begin
      m = ETA_CALC;
    end
    return m;
  endfunction

  logic [15:0] beam_q;
  logic [22:0] lead_q, sublead_q;
  logic [14:0] eta_limit_q, crack_low_q, crack_high_q;
  logic [15:0] min_dr_q;

  logic            adv;
  logic [NSTG-1:0] v_q;

  s1_t s1_d, s1_q;
  sb_t sb_d;
  sb_t sb_q [SBN];

  logic signed [47:0] sq_px1, sq_py1, sq_px2, sq_py2;
  logic signed [16:0] ye, ya;
  logic [47:0]        pt1s, pt2s;
  logic               pt_cut;

  logic [LN_W-1:0]         ln_s, ln_q2, ln_a1, ln_b1, ln_a2, ln_b2;
  logic signed [ANG_W-1:0] ang1, ang2;

  logic signed [21:0]    lim, ay32;
  logic                  rap_cut;
  logic signed [ANG_W:0] dp, dphi_d;

  logic                  cut20_q;
  logic signed [21:0]    eta1_q, eta2_q;
  logic signed [ANG_W:0] dphi_q;
  logic [39:0]           rs20_q;

  logic [20:0]        ae1, ae2;
  logic signed [21:0] ae1w, ae2w;
  logic [18:0]        elim, clo, chi;
  logic               eta_cut;
  logic signed [22:0] deta;
  logic signed [45:0] deta_sq;
  logic signed [41:0] dphi_sq;

  logic        cut21_q;
  logic [42:0] deta2_q;
  logic [40:0] dphi2_q;
  logic [39:0] rs21_q;
  logic [43:0] r2sum;

  logic rej_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q       <= 16'd13000;
      lead_q       <= '0;
      sublead_q    <= '0;
      eta_limit_q  <= 15'd32767;
      crack_low_q  <= '0;
      crack_high_q <= '0;
      min_dr_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BEAM_ENERGY:    beam_q       <= cfg_data_i[15:0];
        REG_LEAD_PT_CUT:    lead_q       <= cfg_data_i;
        REG_SUBLEAD_PT_CUT: sublead_q    <= cfg_data_i;
        REG_ETA_LIMIT:      eta_limit_q  <= cfg_data_i[14:0];
        REG_CRACK_LOW:      crack_low_q  <= cfg_data_i[14:0];
        REG_CRACK_HIGH:     crack_high_q <= cfg_data_i[14:0];
        REG_MIN_DELTA_R:    min_dr_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_comb begin
    sq_px1 = photon1_px_i * photon1_px_i;
    sq_py1 = photon1_py_i * photon1_py_i;
    sq_px2 = photon2_px_i * photon2_px_i;
    sq_py2 = photon2_py_i * photon2_py_i;
    ye     = pair_rapidity_i;
    ya     = (ye < 0) ? -ye : ye;

    s1_d.s      = beam_q * beam_q;
    s1_d.q2     = pair_mass_sq_i;
    s1_d.a1     = $signed({2'b0, photon1_energy_i}) + $signed({photon1_pz_i[23], photon1_pz_i});
    s1_d.b1     = $signed({2'b0, photon1_energy_i}) - $signed({photon1_pz_i[23], photon1_pz_i});
    s1_d.a2     = $signed({2'b0, photon2_energy_i}) + $signed({photon2_pz_i[23], photon2_pz_i});
    s1_d.b2     = $signed({2'b0, photon2_energy_i}) - $signed({photon2_pz_i[23], photon2_pz_i});
    s1_d.px1    = photon1_px_i;
    s1_d.py1    = photon1_py_i;
    s1_d.px2    = photon2_px_i;
    s1_d.py2    = photon2_py_i;
    s1_d.ay     = ya[15:0];
    s1_d.qt_cut = pair_qt_sq_i > {scale_sq_i, 2'b00};
    s1_d.sqx1   = sq_px1[46:0];
    s1_d.sqy1   = sq_py1[46:0];
    s1_d.sqx2   = sq_px2[46:0];
    s1_d.sqy2   = sq_py2[46:0];
    s1_d.c1s    = lead_q * lead_q;
    s1_d.c2s    = sublead_q * sublead_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    pt1s   = {1'b0, s1_q.sqx1} + {1'b0, s1_q.sqy1};
    pt2s   = {1'b0, s1_q.sqx2} + {1'b0, s1_q.sqy2};
    pt_cut = (pt1s < {2'b0, s1_q.c1s} && pt2s < {2'b0, s1_q.c1s}) ||
             pt1s < {2'b0, s1_q.c2s} || pt2s < {2'b0, s1_q.c2s};

    sb_d.q2_nz    = s1_q.q2 != '0;
    sb_d.s_nz     = s1_q.s != '0;
    sb_d.ay       = s1_q.ay;
    sb_d.base_cut = s1_q.qt_cut || pt_cut;
    sb_d.mode1    = eta_mode(s1_q.a1, s1_q.b1);
    sb_d.mode2    = eta_mode(s1_q.a2, s1_q.b2);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= sb_d;
      for (int k = 1; k < SBN; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  dpsc_log #(.XW(32)) u_log_s  (.clk_i, .en_i(adv), .x_i(s1_q.s),        .ln_o(ln_s));
  dpsc_log #(.XW(28)) u_log_q2 (.clk_i, .en_i(adv), .x_i(s1_q.q2),       .ln_o(ln_q2));
  dpsc_log #(.XW(24)) u_log_a1 (.clk_i, .en_i(adv), .x_i(s1_q.a1[23:0]), .ln_o(ln_a1));
  dpsc_log #(.XW(24)) u_log_b1 (.clk_i, .en_i(adv), .x_i(s1_q.b1[23:0]), .ln_o(ln_b1));
  dpsc_log #(.XW(24)) u_log_a2 (.clk_i, .en_i(adv), .x_i(s1_q.a2[23:0]), .ln_o(ln_a2));
  dpsc_log #(.XW(24)) u_log_b2 (.clk_i, .en_i(adv), .x_i(s1_q.b2[23:0]), .ln_o(ln_b2));

  dpsc_cordic u_ang1 (.clk_i, .en_i(adv), .y_i(s1_q.px1), .x_i(s1_q.py1), .ang_o(ang1));
  dpsc_cordic u_ang2 (.clk_i, .en_i(adv), .y_i(s1_q.px2), .x_i(s1_q.py2), .ang_o(ang2));

  always_comb begin
    lim     = $signed({1'b0, ln_s}) - $signed({1'b0, ln_q2});
    ay32    = $signed({1'b0, sb_q[SBN-1].ay, 5'b0});
    rap_cut = sb_q[SBN-1].q2_nz && (!sb_q[SBN-1].s_nz || ay32 > lim);
    dp      = $signed({ang1[ANG_W-1], ang1}) - $signed({ang2[ANG_W-1], ang2});
    if (dp > PI_DPHI) begin
      dphi_d = dp - TWO_PI_DPHI;
    end else if (dp < -PI_DPHI) begin
      dphi_d = dp + TWO_PI_DPHI;
    end else begin
      dphi_d = dp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cut20_q <= sb_q[SBN-1].base_cut || rap_cut;
      eta1_q  <= eta_sel(sb_q[SBN-1].mode1, ln_a1, ln_b1);
      eta2_q  <= eta_sel(sb_q[SBN-1].mode2, ln_a2, ln_b2);
      dphi_q  <= dphi_d;
      rs20_q  <= {min_dr_q, 4'b0} * {min_dr_q, 4'b0};
    end
  end

  always_comb begin
    ae1w    = (eta1_q < 0) ? -eta1_q : eta1_q;
    ae2w    = (eta2_q < 0) ? -eta2_q : eta2_q;
    ae1     = ae1w[20:0];
    ae2     = ae2w[20:0];
    elim    = {eta_limit_q, 4'b0};
    clo     = {crack_low_q, 4'b0};
    chi     = {crack_high_q, 4'b0};
    eta_cut = ae1 > {2'b0, elim} || ae2 > {2'b0, elim} ||
              ({2'b0, clo} < ae1 && ae1 < {2'b0, chi}) ||
              ({2'b0, clo} < ae2 && ae2 < {2'b0, chi});
    deta    = $signed({eta1_q[21], eta1_q}) - $signed({eta2_q[21], eta2_q});
    deta_sq = deta * deta;
    dphi_sq = dphi_q * dphi_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cut21_q <= cut20_q || eta_cut;
      deta2_q <= deta_sq[42:0];
      dphi2_q <= dphi_sq[40:0];
      rs21_q  <= rs20_q;
    end
  end

  assign r2sum = {1'b0, deta2_q} + {3'b0, dphi2_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rej_q <= cut21_q || (r2sum < {4'b0, rs21_q});
    end
  end

  assign out_valid_o = v_q[NSTG-1];
  assign rejected_o  = rej_q;

  `DPSC_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, v_q[0])
  `DPSC_ASSERT_NEXT(a_stall_holds, !adv, v_q == $past(v_q))
  `DPSC_ASSERT_IMPL(a_eta1_range, v_q[19], (eta1_q <= ETA_SAT) && (eta1_q >= -ETA_SAT))
  `DPSC_ASSERT_IMPL(a_eta2_range, v_q[19], (eta2_q <= ETA_SAT) && (eta2_q >= -ETA_SAT))

endmodule
